/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, active through reset.
`define ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/h2rgb_pkg.sv */
package h2rgb_pkg;

  localparam int unsigned UnitQ14        = 16384;
  localparam int unsigned FullTurn       = 360;
  localparam int unsigned SectorSpan     = 60;
  localparam int unsigned ChannelMax     = 255;
  localparam int unsigned FracOne        = 65536;
  // hue + 32768 is offset by 8 mod 360; adding 352 restores the residue
  localparam int unsigned HueOffset      = 352;
  // floor(2^24 / 360): quotient estimate is exact or one low
  localparam int unsigned TurnRecip      = 46603;
  localparam int unsigned TurnRecipShift = 24;

  typedef logic [15:0] frac_lut_t [SectorSpan];

  function automatic frac_lut_t build_frac_lut();
    frac_lut_t lut;
    for (int i = 0; i < SectorSpan; i++) begin
      lut[i] = 16'((i * FracOne) / SectorSpan);
    end
    return lut;
  endfunction

  localparam frac_lut_t FracLut = build_frac_lut();

  typedef enum logic [2:0] {
    SEC_R_TO_Y,
    SEC_Y_TO_G,
    SEC_G_TO_C,
    SEC_C_TO_B,
    SEC_B_TO_M,
    SEC_M_TO_R
  } sector_t;

  typedef struct packed {
    logic signed [15:0] hue_degrees;
    logic signed [15:0] saturation;
    logic signed [15:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

endpackage

/* src/hsv_to_rgb_converter.sv */
// HSV to RGB pixel converter.
// Input: drive in_item and raise start; the item is taken at a clock edge
// where start is high and busy is low. busy is high during reset and for the
// first cycle after it, so a new pixel can be taken on every clock after that.
// Hue is any signed degree value (reduced mod 360); saturation and
// brightness are signed Q2.14, clamped to 0..1.
// Output: out_valid is high for one cycle with red/green/blue on out_item.
// Pipeline: seven register stages, the last being the output register.
// Throughput: one pixel per cycle once busy is low; the per-stage
// multipliers (hue reciprocal, V*(1-S), S*f, V*(1-S*f)) set the stage split.
// Reset (synchronous, active low) clears all valid bits; items in flight
// are dropped and out_valid is low afterwards.
// The receiver cannot stall: each result is shown for exactly one cycle
// and must be taken then.
module hsv_to_rgb_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  h2rgb_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output h2rgb_pkg::out_item_t out_item
);
  import h2rgb_pkg::*;

  logic        busy_r;
  logic        accept;
  logic [5:0]  vld_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  out_item_t   out_item_nxt;

  // stage 1
  logic [16:0] x1_nxt, x1_r;
  logic [32:0] hq_prod;
  logic [7:0]  qe1_nxt, qe1_r;
  logic [14:0] s1_nxt, s1_r, v1_nxt, v1_r;
  // stage 2
  logic [16:0] hue_w;
  logic [8:0]  hue2_nxt, hue2_r;
  logic [29:0] p_prod;
  logic [14:0] p2_nxt, p2_r, s2_r, v2_r;
  // stage 3
  sector_t     sec3_nxt, sec3_r;
  logic [8:0]  base3;
  logic [5:0]  rem3_nxt, rem3_r;
  logic [14:0] p3_r, s3_r, v3_r;
  // stage 4
  logic [15:0] f4_nxt, f4_r;
  logic [16:0] g4_nxt, g4_r;
  logic [14:0] p4_r, s4_r, v4_r;
  sector_t     sec4_r;
  // stage 5
  logic [30:0] s_f_prod;
  logic [31:0] sg_prod;
  logic [14:0] qa5_nxt, qa5_r, ta5_nxt, ta5_r, p5_r, v5_r;
  sector_t     sec5_r;
  // stage 6
  logic [29:0] q_prod, t_prod;
  logic [14:0] q6_nxt, q6_r, t6_nxt, t6_r, p6_r, v6_r;
  sector_t     sec6_r;
  // stage 7
  logic [14:0] r_comp, g_comp, b_comp;
  logic [22:0] r_scl, g_scl, b_scl;

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  function automatic logic [14:0] clamp_unit(logic signed [15:0] val);
    logic [14:0] res;
    if (val[15]) begin
      res = '0;
    end else if (val > 16'(UnitQ14)) begin
      res = 15'(UnitQ14);
    end else begin
      res = val[14:0];
    end
    return res;
  endfunction

  function automatic logic [7:0] to_channel(logic [22:0] scaled);
    return scaled[21:14];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[4:0], accept};
      out_valid_r <= vld_r[5];
    end
  end

  // stage 1: hue offset, reciprocal quotient estimate, clamps
  always_comb begin
    x1_nxt  = 17'({~in_item.hue_degrees[15], in_item.hue_degrees[14:0]}) + 17'(HueOffset);
    hq_prod = 33'(x1_nxt) * 33'(TurnRecip);
    qe1_nxt = hq_prod[TurnRecipShift +: 8];
    s1_nxt  = clamp_unit(in_item.saturation);
    v1_nxt  = clamp_unit(in_item.brightness);
  end

  // stage 2: hue mod 360 with one correction, p
  always_comb begin
    hue_w    = x1_r - 17'(qe1_r) * 17'(FullTurn);
    hue2_nxt = (hue_w >= 17'(FullTurn)) ? 9'(hue_w - 17'(FullTurn)) : 9'(hue_w);
    p_prod   = 30'(v1_r) * 30'(15'(UnitQ14) - s1_r);
    p2_nxt   = p_prod[28:14];
  end

  // stage 3: sector and remainder
  always_comb begin
    priority if (hue2_r < 9'(SectorSpan)) begin
      sec3_nxt = SEC_R_TO_Y;
      base3    = 9'd0;
    end else if (hue2_r < 9'(2 * SectorSpan)) begin
      sec3_nxt = SEC_Y_TO_G;
      base3    = 9'(SectorSpan);
    end else if (hue2_r < 9'(3 * SectorSpan)) begin
      sec3_nxt = SEC_G_TO_C;
      base3    = 9'(2 * SectorSpan);
    end else if (hue2_r < 9'(4 * SectorSpan)) begin
      sec3_nxt = SEC_C_TO_B;
      base3    = 9'(3 * SectorSpan);
    end else if (hue2_r < 9'(5 * SectorSpan)) begin
      sec3_nxt = SEC_B_TO_M;
      base3    = 9'(4 * SectorSpan);
    end else begin
      sec3_nxt = SEC_M_TO_R;
      base3    = 9'(5 * SectorSpan);
    end
    rem3_nxt = 6'(hue2_r - base3);
  end

  // stage 4: fraction and its complement
  always_comb begin
    f4_nxt = FracLut[rem3_r];
    g4_nxt = 17'(FracOne) - 17'(f4_nxt);
  end

  // stage 5: 1 - S*f and 1 - S*(1-f)
  always_comb begin
    s_f_prod = 31'(s4_r) * 31'(f4_r);
    sg_prod  = 32'(s4_r) * 32'(g4_r);
    qa5_nxt  = 15'(UnitQ14) - s_f_prod[30:16];
    ta5_nxt  = 15'(UnitQ14) - sg_prod[30:16];
  end

  // stage 6: q and t
  always_comb begin
    q_prod = 30'(v5_r) * 30'(qa5_r);
    t_prod = 30'(v5_r) * 30'(ta5_r);
    q6_nxt = q_prod[28:14];
    t6_nxt = t_prod[28:14];
  end

  // stage 7: channel order and scaling by 255
  always_comb begin
    unique case (sec6_r)
      SEC_Y_TO_G: begin
        r_comp = q6_r; g_comp = v6_r; b_comp = p6_r;
      end
      SEC_G_TO_C: begin
        r_comp = p6_r; g_comp = v6_r; b_comp = t6_r;
      end
      SEC_C_TO_B: begin
        r_comp = p6_r; g_comp = q6_r; b_comp = v6_r;
      end
      SEC_B_TO_M: begin
        r_comp = t6_r; g_comp = p6_r; b_comp = v6_r;
      end
      SEC_M_TO_R: begin
        r_comp = v6_r; g_comp = p6_r; b_comp = q6_r;
      end
      default: begin
        r_comp = v6_r; g_comp = t6_r; b_comp = p6_r;
      end
    endcase
    r_scl = {r_comp, 8'd0} - 23'(r_comp);
    g_scl = {g_comp, 8'd0} - 23'(g_comp);
    b_scl = {b_comp, 8'd0} - 23'(b_comp);
    out_item_nxt.red   = to_channel(r_scl);
    out_item_nxt.green = to_channel(g_scl);
    out_item_nxt.blue  = to_channel(b_scl);
  end

  always_ff @(posedge clk) begin
    x1_r   <= x1_nxt;
    qe1_r  <= qe1_nxt;
    s1_r   <= s1_nxt;
    v1_r   <= v1_nxt;

    hue2_r <= hue2_nxt;
    p2_r   <= p2_nxt;
    s2_r   <= s1_r;
    v2_r   <= v1_r;

    sec3_r <= sec3_nxt;
    rem3_r <= rem3_nxt;
    p3_r   <= p2_r;
    s3_r   <= s2_r;
    v3_r   <= v2_r;

    f4_r   <= f4_nxt;
    g4_r   <= g4_nxt;
    sec4_r <= sec3_r;
    p4_r   <= p3_r;
    s4_r   <= s3_r;
    v4_r   <= v3_r;

    qa5_r  <= qa5_nxt;
    ta5_r  <= ta5_nxt;
    sec5_r <= sec4_r;
    p5_r   <= p4_r;
    v5_r   <= v4_r;

    q6_r   <= q6_nxt;
    t6_r   <= t6_nxt;
    sec6_r <= sec5_r;
    p6_r   <= p5_r;
    v6_r   <= v5_r;

    out_item_r <= out_item_nxt;
  end

endmodule

/* src/h2rgb_checker.sv */
`include "assert_macros.svh"

module h2rgb_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input h2rgb_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input h2rgb_pkg::out_item_t out_item
);
  import h2rgb_pkg::*;

  `ASSERT_NXT(a_rst_quiet, clk, !rst_n, !out_valid)
  `ASSERT_IMP(a_result_follows, clk, rst_n, start && !busy, ##7 out_valid)
  `ASSERT_IMP(a_no_spurious, clk, rst_n, out_valid, $past(start && !busy, 7))
  `ASSERT_IMP(a_gray_pixel, clk, rst_n, start && !busy && (in_item.saturation[15] || in_item.saturation == 16'd0), ##7 (out_item.red == out_item.green && out_item.green == out_item.blue))

endmodule

bind hsv_to_rgb_converter h2rgb_checker u_h2rgb_checker (.*);
